[rtl/atcp_pkg.sv]
// Shared types, character codes and command table for the ASCII tuning command parser.
`timescale 1ns / 1ps

package atcp_pkg;

    localparam int VALUE_MAX_LEN = 12;
    localparam int LEN_W = $clog2(VALUE_MAX_LEN + 1);

    localparam int MANT_W = 40;
    localparam int FRAC_W = 4;
    localparam int CMD_W = 3;
    localparam int CMD_COUNT = 6;

    localparam logic [MANT_W-1:0] MANT_MAX = MANT_W'(64'd999999999999);
    // The largest mantissa that can take one more digit without passing the maximum.
    // It is the same for every digit value because the maximum ends in nine.
    localparam logic [MANT_W-1:0] MANT_THR = MANT_W'(64'd999999999999 / 64'd10);
    localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_V = 8'h56;

    typedef enum logic [2:0] {
        FP_HEAD1  = 3'd0,
        FP_HEAD2  = 3'd1,
        FP_CMD1   = 3'd2,
        FP_CMD2   = 3'd3,
        FP_VALUE  = 3'd4,
        FP_TAIL2  = 3'd5
    } frame_phase_t;

    typedef enum logic [2:0] {
        NP_START = 3'd0,
        NP_INT   = 3'd1,
        NP_FRAC  = 3'd2,
        NP_END   = 3'd3,
        NP_BAD   = 3'd4
    } number_phase_t;

    typedef enum logic [1:0] {
        KIND_VOLT_PI = 2'd0,
        KIND_CURR_PI = 2'd1,
        KIND_TARGET  = 2'd2
    } update_kind_t;

    typedef struct packed {
        logic             hit;
        logic [CMD_W-1:0] index;
        update_kind_t     kind;
    } cmd_match_t;

    localparam logic [7:0] CMD_FIRST [CMD_COUNT] = '{CH_V, CH_V, CH_I, CH_I, CH_V, CH_I};
    localparam logic [7:0] CMD_SECOND [CMD_COUNT] = '{CH_P, CH_I, CH_P, CH_I, CH_T, CH_T};
    localparam update_kind_t CMD_KIND [CMD_COUNT] = '{
        KIND_VOLT_PI, KIND_VOLT_PI, KIND_CURR_PI, KIND_CURR_PI, KIND_TARGET, KIND_TARGET
    };

    function automatic cmd_match_t cmd_lookup(input logic [7:0] first, input logic [7:0] second);
        cmd_match_t m;
        m.hit = 1'b0;
        m.index = '0;
        m.kind = KIND_VOLT_PI;
        for (int i = 0; i < CMD_COUNT; i++) begin
            if (!m.hit && first == CMD_FIRST[i] && second == CMD_SECOND[i]) begin
                m.hit = 1'b1;
                m.index = CMD_W'(i);
                m.kind = CMD_KIND[i];
            end
        end
        return m;
    endfunction

endpackage

[rtl/ascii_tuning_command_parser.sv]
// Top level of the ASCII tuning command parser: frame tracking, value parsing and command match.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------------
//  in      | input     | in_valid / in_stall | rx_byte, converter_in_error
//  out     | output    | out_valid/out_stall | command_index, value_mantissa, fraction_digits,
//          |           |                     | update_kind, request_wait_change
//
// Each byte word is taken into an input register and is parsed from there by the frame and
// number logic, whose critical path is the times-ten update of the 40-bit mantissa. A new
// byte can be accepted in every cycle while no stalled result word holds the input, and a
// result word is loaded into the output register at the edge that ends the parse of the
// closing byte. Reset clears all parser state.
// While a result word waits with out_stall high, parsing of further bytes pauses and in_stall
// rises once the input register is full.
`timescale 1ns / 1ps

module ascii_tuning_command_parser
    import atcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    input  logic              converter_in_error,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CMD_W-1:0]  command_index,
    output logic [MANT_W-1:0] value_mantissa,
    output logic [FRAC_W-1:0] fraction_digits,
    output logic [1:0]        update_kind,
    output logic              request_wait_change
);

    logic              in_full_reg;
    logic [7:0]        byte_reg;
    logic              err_reg;

    frame_phase_t      frame_reg, frame_next;
    logic [7:0]        first_reg, first_next;
    logic [7:0]        second_reg, second_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [MANT_W-1:0] acc_reg, acc_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    number_phase_t     number_reg, number_next;
    logic              saw_reg, saw_next;
    logic              neg_reg, neg_next;

    logic              out_valid_reg;
    logic [CMD_W-1:0]  index_reg;
    logic [MANT_W-1:0] mant_reg;
    logic [FRAC_W-1:0] digits_reg;
    update_kind_t      kind_reg;
    logic              wait_reg;

    logic              fire;
    logic              result_hit;
    cmd_match_t        match;
    logic              is_digit;
    logic [MANT_W-1:0] acc_times10;
    logic              acc_over;

    assign fire = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (!in_full_reg || fire)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((!in_full_reg || fire) && in_valid)
        begin
            byte_reg <= rx_byte;
            err_reg <= converter_in_error;
        end
    end

    assign match = cmd_lookup(first_reg, second_reg);
    assign is_digit = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
    assign acc_over = acc_reg > MANT_THR;
    assign acc_times10 = {acc_reg[MANT_W-4:0], 3'b000} + {acc_reg[MANT_W-2:0], 1'b0}
                       + MANT_W'(byte_reg[3:0]);

    always_comb
    begin
        frame_next = frame_reg;
        first_next = first_reg;
        second_next = second_reg;
        length_next = length_reg;
        acc_next = acc_reg;
        frac_next = frac_reg;
        number_next = number_reg;
        saw_next = saw_reg;
        neg_next = neg_reg;
        result_hit = 1'b0;

        unique case (frame_reg)
            FP_HEAD1:
            begin
                if (byte_reg == CH_A)
                begin
                    frame_next = FP_HEAD2;
                end
            end
            FP_HEAD2:
            begin
                frame_next = (byte_reg == CH_A) ? FP_CMD1 : FP_HEAD1;
            end
            FP_CMD1:
            begin
                first_next = byte_reg;
                frame_next = FP_CMD2;
            end
            FP_CMD2:
            begin
                second_next = byte_reg;
                length_next = '0;
                acc_next = '0;
                frac_next = '0;
                number_next = NP_START;
                saw_next = 1'b0;
                neg_next = 1'b0;
                frame_next = FP_VALUE;
            end
            FP_VALUE:
            begin
                priority if (byte_reg == CH_B)
                begin
                    frame_next = FP_TAIL2;
                end
                else if (length_reg < LEN_W'(VALUE_MAX_LEN))
                begin
                    length_next = LEN_W'(length_reg + 1'b1);
                    unique case (number_reg)
                        NP_START:
                        begin
                            priority if (byte_reg == CH_MINUS)
                            begin
                                neg_next = 1'b1;
                                number_next = NP_INT;
                            end
                            else if (byte_reg == CH_PLUS)
                            begin
                                number_next = NP_INT;
                            end
                            else if (is_digit)
                            begin
                                saw_next = 1'b1;
                                acc_next = acc_over ? MANT_MAX : acc_times10;
                                number_next = NP_INT;
                            end
                            else if (byte_reg == CH_POINT)
                            begin
                                number_next = NP_FRAC;
                            end
                            else if (byte_reg == CH_NUL)
                            begin
                                number_next = NP_END;
                            end
                            else
                            begin
                                number_next = NP_BAD;
                            end
                        end
                        NP_INT:
                        begin
                            priority if (is_digit)
                            begin
                                saw_next = 1'b1;
                                acc_next = acc_over ? MANT_MAX : acc_times10;
                            end
                            else if (byte_reg == CH_POINT)
                            begin
                                number_next = NP_FRAC;
                            end
                            else if (byte_reg == CH_NUL)
                            begin
                                number_next = NP_END;
                            end
                            else
                            begin
                                number_next = NP_BAD;
                            end
                        end
                        NP_FRAC:
                        begin
                            priority if (is_digit)
                            begin
                                saw_next = 1'b1;
                                // A fraction digit that does not fit is dropped.
                                if (!acc_over)
                                begin
                                    acc_next = acc_times10;
                                    if (frac_reg != FRAC_MAX)
                                    begin
                                        frac_next = FRAC_W'(frac_reg + 1'b1);
                                    end
                                end
                            end
                            else if (byte_reg == CH_NUL)
                            begin
                                number_next = NP_END;
                            end
                            else
                            begin
                                number_next = NP_BAD;
                            end
                        end
                        default:
                        begin
                            number_next = number_reg;
                        end
                    endcase
                end
                else
                begin
                    frame_next = FP_HEAD1;
                    length_next = '0;
                end
            end
            FP_TAIL2:
            begin
                result_hit = (byte_reg == CH_B) && (number_reg != NP_BAD) && saw_reg
                           && !(neg_reg && acc_reg != '0) && match.hit;
                frame_next = FP_HEAD1;
                length_next = '0;
            end
            default:
            begin
                frame_next = FP_HEAD1;
                length_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= FP_HEAD1;
            first_reg <= '0;
            second_reg <= '0;
            length_reg <= '0;
            acc_reg <= '0;
            frac_reg <= '0;
            number_reg <= NP_START;
            saw_reg <= 1'b0;
            neg_reg <= 1'b0;
        end
        else if (fire)
        begin
            frame_reg <= frame_next;
            first_reg <= first_next;
            second_reg <= second_next;
            length_reg <= length_next;
            acc_reg <= acc_next;
            frac_reg <= frac_next;
            number_reg <= number_next;
            saw_reg <= saw_next;
            neg_reg <= neg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && result_hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && result_hit)
        begin
            index_reg <= match.index;
            mant_reg <= acc_reg;
            digits_reg <= frac_reg;
            kind_reg <= match.kind;
            wait_reg <= (match.kind == KIND_TARGET) && !err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign command_index = index_reg;
    assign value_mantissa = mant_reg;
    assign fraction_digits = digits_reg;
    assign update_kind = kind_reg;
    assign request_wait_change = wait_reg;

endmodule

[rtl/atcp_checker.sv]
// Port-level checker for the ASCII tuning command parser and its bind to the top level.
`timescale 1ns / 1ps

module atcp_checker
    import atcp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [CMD_W-1:0]  command_index,
    input logic [MANT_W-1:0] value_mantissa,
    input logic [1:0]        update_kind,
    input logic              request_wait_change
);

    // A stalled result word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // The kind of update follows from the command.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (command_index <= CMD_W'(CMD_COUNT - 1))
                      && (update_kind == command_index[2:1]))
        else $error("command and update kind disagree");

    // A waiting-change request only comes with a target set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && request_wait_change |-> update_kind == KIND_TARGET)
        else $error("waiting-change request without target set");

    // The mantissa never passes its saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> value_mantissa <= MANT_MAX)
        else $error("mantissa above its limit");

    // A result needs the closing tail of a new frame, so a new byte word must be accepted between results.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid || $past(in_valid && !in_stall))
        else $error("result word without a new byte word");

endmodule

bind ascii_tuning_command_parser atcp_checker u_atcp_checker (.*);

[dv/ascii_tuning_command_parser_tb.sv]
// Self-checking testbench for the ASCII tuning command parser: byte frames in, tuning updates out.
`timescale 1ns / 1ps

module ascii_tuning_command_parser_tb;
    import atcp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_LIMIT = 10;
    localparam int NUM_CMDS = 6;
    localparam int PHASE_WORDS = 290;
    localparam int PHASE_UPDATES = 15;

    localparam logic [7:0] LETTER_HI [NUM_CMDS] = '{CH_V, CH_V, CH_I, CH_I, CH_V, CH_I};
    localparam logic [7:0] LETTER_LO [NUM_CMDS] = '{CH_P, CH_I, CH_P, CH_I, CH_T, CH_T};
    localparam update_kind_t KIND_OF [NUM_CMDS] = '{
        KIND_VOLT_PI, KIND_VOLT_PI, KIND_CURR_PI, KIND_CURR_PI, KIND_TARGET, KIND_TARGET
    };

    typedef struct {
        logic [CMD_W-1:0]  index;
        logic [MANT_W-1:0] mantissa;
        logic [FRAC_W-1:0] frac;
        update_kind_t      kind;
        logic              wait_req;
    } tuning_update_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        rx_byte = '0;
    logic              converter_in_error = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CMD_W-1:0]  command_index;
    logic [MANT_W-1:0] value_mantissa;
    logic [FRAC_W-1:0] fraction_digits;
    logic [1:0]        update_kind;
    logic              request_wait_change;

    frame_phase_t      frame_at = FP_HEAD1;
    number_phase_t     number_at = NP_START;
    logic [7:0]        letter_hi_q = '0;
    logic [7:0]        letter_lo_q = '0;
    logic [LEN_W-1:0]  value_count = '0;
    logic [MANT_W-1:0] mantissa_acc = '0;
    logic [FRAC_W-1:0] frac_acc = '0;
    logic              digit_seen = 1'b0;
    logic              minus_seen = 1'b0;

    tuning_update_t    expected_updates [$];
    logic [7:0]        value_bytes [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int words_sent = 0;
    int directed_words = 0;
    int updates_expected = 0;
    int targets_expected = 0;
    int updates_checked = 0;
    int mismatches = 0;

    ascii_tuning_command_parser dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .rx_byte             (rx_byte),
        .converter_in_error  (converter_in_error),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .command_index       (command_index),
        .value_mantissa      (value_mantissa),
        .fraction_digits     (fraction_digits),
        .update_kind         (update_kind),
        .request_wait_change (request_wait_change)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void take_digit(input logic [3:0] d, input logic frac_part);
        digit_seen = 1'b1;
        if (mantissa_acc > (MANT_MAX - MANT_W'(d)) / 10)
        begin
            if (!frac_part)
                mantissa_acc = MANT_MAX;
        end
        else
        begin
            mantissa_acc = mantissa_acc * 10 + MANT_W'(d);
            if (frac_part && frac_acc != FRAC_MAX)
                frac_acc = frac_acc + 1'b1;
        end
    endfunction

    function automatic void parse_value_char(input logic [7:0] c);
        logic       is_digit;
        logic [3:0] d;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d = 4'(c - CH_ZERO);
        case (number_at)
            NP_START:
            begin
                if (c == CH_MINUS)
                begin
                    minus_seen = 1'b1;
                    number_at = NP_INT;
                end
                else if (c == CH_PLUS)
                    number_at = NP_INT;
                else if (is_digit)
                begin
                    take_digit(d, 1'b0);
                    number_at = NP_INT;
                end
                else if (c == CH_POINT)
                    number_at = NP_FRAC;
                else if (c == CH_NUL)
                    number_at = NP_END;
                else
                    number_at = NP_BAD;
            end
            NP_INT:
            begin
                if (is_digit)
                    take_digit(d, 1'b0);
                else if (c == CH_POINT)
                    number_at = NP_FRAC;
                else if (c == CH_NUL)
                    number_at = NP_END;
                else
                    number_at = NP_BAD;
            end
            NP_FRAC:
            begin
                if (is_digit)
                    take_digit(d, 1'b1);
                else if (c == CH_NUL)
                    number_at = NP_END;
                else
                    number_at = NP_BAD;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void close_frame(input logic err);
        tuning_update_t upd;
        if (number_at == NP_BAD || !digit_seen)
            return;
        if (minus_seen && mantissa_acc != '0)
            return;
        for (int k = 0; k < NUM_CMDS; k++)
        begin
            if (letter_hi_q == LETTER_HI[k] && letter_lo_q == LETTER_LO[k])
            begin
                upd.index = CMD_W'(k);
                upd.mantissa = mantissa_acc;
                upd.frac = frac_acc;
                upd.kind = KIND_OF[k];
                upd.wait_req = (KIND_OF[k] == KIND_TARGET) && !err;
                expected_updates.push_back(upd);
                updates_expected++;
                if (KIND_OF[k] == KIND_TARGET)
                    targets_expected++;
                return;
            end
        end
    endfunction

    function automatic void predict_word(input logic [7:0] c, input logic err);
        case (frame_at)
            FP_HEAD1:
            begin
                if (c == CH_A)
                    frame_at = FP_HEAD2;
            end
            FP_HEAD2:
            begin
                if (c == CH_A)
                    frame_at = FP_CMD1;
                else
                    frame_at = FP_HEAD1;
            end
            FP_CMD1:
            begin
                letter_hi_q = c;
                frame_at = FP_CMD2;
            end
            FP_CMD2:
            begin
                letter_lo_q = c;
                value_count = '0;
                mantissa_acc = '0;
                frac_acc = '0;
                number_at = NP_START;
                digit_seen = 1'b0;
                minus_seen = 1'b0;
                frame_at = FP_VALUE;
            end
            FP_VALUE:
            begin
                if (c == CH_B)
                    frame_at = FP_TAIL2;
                else if (value_count < VALUE_MAX_LEN)
                begin
                    parse_value_char(c);
                    value_count = value_count + 1'b1;
                end
                else
                begin
                    frame_at = FP_HEAD1;
                    value_count = '0;
                end
            end
            FP_TAIL2:
            begin
                if (c == CH_B)
                    close_frame(err);
                frame_at = FP_HEAD1;
                value_count = '0;
            end
            default:
            begin
                frame_at = FP_HEAD1;
                value_count = '0;
            end
        endcase
    endfunction

    function automatic void check_update();
        tuning_update_t want;
        if (expected_updates.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("Unexpected update: cmd %0d mantissa %0d frac %0d kind %0d wait %0b",
                         command_index, value_mantissa, fraction_digits, update_kind,
                         request_wait_change);
        end
        else
        begin
            want = expected_updates.pop_front();
            updates_checked++;
            if (command_index !== want.index || value_mantissa !== want.mantissa ||
                fraction_digits !== want.frac || update_kind !== want.kind ||
                request_wait_change !== want.wait_req)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("Update mismatch, expected cmd %0d mantissa %0d frac %0d %s",
                             want.index, want.mantissa, want.frac, "");
                    $display("    expected kind %0d wait %0b", want.kind, want.wait_req);
                    $display("    actual   cmd %0d mantissa %0d frac %0d kind %0d wait %0b",
                             command_index, value_mantissa, fraction_digits, update_kind,
                             request_wait_change);
                end
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (out_valid && !out_stall)
                check_update();
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles with %0d updates outstanding.",
                 cycle_count, expected_updates.size());
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_word(input logic [7:0] b, input logic err);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        converter_in_error <= err;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_word(b, err);
        words_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_updates.size() != 0)
            @(posedge clk);
    endtask

    function automatic void load_text(input string text);
        value_bytes.delete();
        for (int i = 0; i < text.len(); i++)
            value_bytes.push_back(text[i]);
    endfunction

    task automatic send_frame(input logic [7:0] hi, input logic [7:0] lo,
                              input logic [7:0] tail, input logic err);
        send_word(CH_A, err);
        send_word(CH_A, err);
        send_word(hi, err);
        send_word(lo, err);
        foreach (value_bytes[i])
            send_word(value_bytes[i], err);
        send_word(CH_B, err);
        send_word(tail, err);
    endtask

    task automatic send_text_frame(input logic [7:0] hi, input logic [7:0] lo,
                                   input string text, input logic err);
        load_text(text);
        send_frame(hi, lo, CH_B, err);
    endtask

    task automatic test_commands();
        send_text_frame(CH_V, CH_P, "12.5", 1'b0);
        send_text_frame(CH_V, CH_I, "+0.0625", 1'b1);
        send_text_frame(CH_I, CH_P, ".5", 1'b0);
        send_text_frame(CH_I, CH_I, "007", 1'b1);
        send_text_frame(CH_V, CH_T, "999999999999", 1'b0);
        send_text_frame(CH_V, CH_T, "48", 1'b1);
        send_text_frame(CH_I, CH_T, "0.0000000001", 1'b0);
        send_text_frame(CH_I, CH_T, "3.", 1'b1);
    endtask

    task automatic test_frame_errors();
        send_word(CH_A, 1'b0);
        send_word("x", 1'b1);
        send_text_frame(CH_A, CH_A, "5", 1'b0);
        send_text_frame("X", "Y", "5", 1'b1);
        load_text("5");
        send_frame(CH_V, CH_P, "x", 1'b0);
        send_text_frame(CH_V, CH_P, "1234567890123", 1'b0);
        send_text_frame(CH_I, CH_P, "", 1'b0);
    endtask

    task automatic test_value_forms();
        load_text("12");
        value_bytes.push_back(CH_NUL);
        value_bytes.push_back(CH_MINUS);
        value_bytes.push_back("x");
        send_frame(CH_I, CH_P, CH_B, 1'b0);
        load_text("");
        value_bytes.push_back(CH_NUL);
        send_frame(CH_V, CH_I, CH_B, 1'b0);
        send_text_frame(CH_V, CH_P, "1x2", 1'b0);
        send_text_frame(CH_V, CH_P, "+-1", 1'b0);
        send_text_frame(CH_V, CH_P, "1.2.3", 1'b0);
        send_text_frame(CH_I, CH_I, "+", 1'b0);
        send_text_frame(CH_I, CH_I, ".", 1'b0);
        send_text_frame(CH_I, CH_I, "-", 1'b0);
        send_text_frame(CH_V, CH_T, "-5", 1'b0);
        send_text_frame(CH_V, CH_T, "-0.00", 1'b0);
    endtask

    function automatic logic [7:0] random_digit(input logic zero_only);
        if (zero_only)
            return CH_ZERO;
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_value_char();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return random_digit(1'b0);
        if (pick == 6)
            return CH_POINT;
        if (pick == 7)
            return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
        if (pick == 8)
            return CH_NUL;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void build_number();
        int   sign_pick;
        int   n_int;
        int   n_frac;
        logic zero_only;
        n_frac = 0;
        zero_only = 1'b0;
        sign_pick = $urandom_range(0, 9);
        if (sign_pick < 2)
        begin
            value_bytes.push_back(CH_MINUS);
            zero_only = 1'($urandom_range(0, 1));
        end
        else if (sign_pick == 2)
            value_bytes.push_back(CH_PLUS);
        n_int = ($urandom_range(0, 7) == 0) ? VALUE_MAX_LEN : $urandom_range(0, 5);
        repeat (n_int)
            value_bytes.push_back(random_digit(zero_only));
        if ($urandom_range(0, 1))
        begin
            value_bytes.push_back(CH_POINT);
            n_frac = $urandom_range(0, 7);
            repeat (n_frac)
                value_bytes.push_back(random_digit(zero_only));
        end
        if (n_int == 0 && n_frac == 0)
            value_bytes.push_back(random_digit(zero_only));
        while (value_bytes.size() > VALUE_MAX_LEN)
            void'(value_bytes.pop_back());
    endfunction

    task automatic random_frame();
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] tail;
        int         pick;
        int         style;
        pick = $urandom_range(0, 9);
        if (pick < 8)
        begin
            style = $urandom_range(0, NUM_CMDS - 1);
            hi = LETTER_HI[style];
            lo = LETTER_LO[style];
        end
        else if (pick == 8)
        begin
            hi = LETTER_LO[$urandom_range(0, NUM_CMDS - 1)];
            lo = LETTER_HI[$urandom_range(0, NUM_CMDS - 1)];
        end
        else
        begin
            hi = 8'($urandom_range(0, 255));
            lo = 8'($urandom_range(0, 255));
        end
        value_bytes.delete();
        style = $urandom_range(0, 9);
        if (style < 7)
            build_number();
        else if (style == 7)
        begin
            build_number();
            if (value_bytes.size() < VALUE_MAX_LEN)
                value_bytes.push_back(CH_NUL);
            repeat ($urandom_range(0, 3))
                if (value_bytes.size() < VALUE_MAX_LEN)
                    value_bytes.push_back(random_value_char());
        end
        else if (style == 8)
        begin
            repeat ($urandom_range(0, VALUE_MAX_LEN))
                value_bytes.push_back(random_value_char());
        end
        else
        begin
            repeat ($urandom_range(VALUE_MAX_LEN + 1, VALUE_MAX_LEN + 3))
                value_bytes.push_back(random_digit(1'b0));
        end
        tail = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255)) : CH_B;
        send_frame(hi, lo, tail, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3))
                send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct);
        int first_word;
        int first_update;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        first_word = words_sent;
        first_update = updates_expected;
        while (words_sent - first_word < PHASE_WORDS ||
               updates_expected - first_update < PHASE_UPDATES)
            random_frame();
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_commands();
        test_frame_errors();
        test_value_forms();
        wait_drained();
        directed_words = words_sent;
        test_random(0, 0);
        test_random(48, 0);
        test_random(0, 48);
        test_random(37, 37);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d byte words, %0d of them directed; checked %0d updates (%0d targets).",
                 words_sent, directed_words, updates_checked, targets_expected);
        $display("Random frames ran with free flow, sender gaps, receiver stalls and both.");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
rtl/atcp_pkg.sv
rtl/ascii_tuning_command_parser.sv
rtl/atcp_checker.sv
dv/ascii_tuning_command_parser_tb.sv
